// ===== rtl/i2cfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the framed I2C master transaction core.
// Holds the transaction structs, request codes and bus command codes; no dependencies.
package i2cfm_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;

    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_RSTART = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_SEND   = 3'd4;
    localparam logic [2:0] CMD_CLOCK  = 3'd5;
    localparam logic [2:0] CMD_ACK    = 3'd6;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] slave_address;
        logic [7:0] tx_count;
        logic [8:0] rx_size;
        logic [7:0] load_index;
        logic [7:0] load_byte;
        logic       arbitration_lost;
        logic       slave_acked;
        logic [7:0] received_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] send_byte;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_data;
        logic       done_res;
        logic       checksum_error;
        logic [8:0] rx_count;
        logic       rejected;
        logic       busy_res;
    } t_out_item;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [7:0] data;
    } t_store_wr;

endpackage

// ===== rtl/i2cfm_tx_store.sv =====
`timescale 1ns / 1ps
// Transmit byte store with one write port and one registered read port.
// Depends on i2cfm_pkg for the write request struct.
module i2cfm_tx_store #(
    parameter int DEPTH = 256
) (
    input  logic                  i_clk,
    input  i2cfm_pkg::t_store_wr  i_wr,
    input  logic [8:0]            i_rd_pos,
    output logic [7:0]            o_rd_data
);
    import i2cfm_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_oob;
    logic          wr_ok;
    logic          rd_oob;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_ok   = i_wr.en && ({1'b0, i_wr.idx} < 9'(DEPTH));
    assign rd_oob  = i_rd_pos >= 9'(DEPTH);
    assign wr_addr = i_wr.idx[AW-1:0];
    assign rd_addr = i_rd_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oob <= rd_oob;
        if (wr_ok && !rd_oob && wr_addr == rd_addr) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_oob ? 8'd0 : r_rd_data;

endmodule

// ===== rtl/i2cfm_seq.sv =====
`timescale 1ns / 1ps
// Transaction sequencer: phase state, check sum and next-state logic for one item.
// Depends on i2cfm_pkg for the transaction structs and command codes.
module i2cfm_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  i2cfm_pkg::t_in_item   i_item,
    input  logic [7:0]            i_rd_data,
    output i2cfm_pkg::t_store_wr  o_store_wr,
    output logic [8:0]            o_rd_pos,
    output i2cfm_pkg::t_out_item  o_result
);
    import i2cfm_pkg::*;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_ADDR   = 4'd1;
    localparam logic [3:0] PH_SLEN   = 4'd2;
    localparam logic [3:0] PH_SDATA  = 4'd3;
    localparam logic [3:0] PH_SCHK   = 4'd4;
    localparam logic [3:0] PH_SFIN   = 4'd5;
    localparam logic [3:0] PH_RSTART = 4'd6;
    localparam logic [3:0] PH_RLEN   = 4'd7;
    localparam logic [3:0] PH_RDATA  = 4'd8;
    localparam logic [3:0] PH_RCHK   = 4'd9;
    localparam logic [3:0] PH_WSTOP  = 4'd10;

    logic [3:0] r_phase, n_phase;
    logic       r_wmode, n_wmode;
    logic [8:0] r_pos, n_pos;
    logic [8:0] r_limit, n_limit;
    logic [7:0] r_sum, n_sum;
    logic       r_await, n_await;
    logic [6:0] r_addr, n_addr;
    logic [7:0] r_txc, n_txc;
    logic [8:0] r_rxs, n_rxs;
    logic       r_err, n_err;

    logic [8:0] pos_inc;
    logic [7:0] addr_byte;
    logic [8:0] rbyte_w;
    logic [8:0] rlen_min;

    assign pos_inc   = r_pos + 9'd1;
    assign addr_byte = {r_addr, ~r_wmode};
    assign rbyte_w   = {1'b0, i_item.received_byte};
    assign rlen_min  = (rbyte_w < r_rxs) ? rbyte_w : r_rxs;

    always_comb begin
        n_phase  = r_phase;
        n_wmode  = r_wmode;
        n_pos    = r_pos;
        n_limit  = r_limit;
        n_sum    = r_sum;
        n_await  = r_await;
        n_addr   = r_addr;
        n_txc    = r_txc;
        n_rxs    = r_rxs;
        n_err    = r_err;
        o_result = '0;
        o_store_wr.en   = 1'b0;
        o_store_wr.idx  = i_item.load_index;
        o_store_wr.data = i_item.load_byte;

        if (i_fire) begin
            case (i_item.req_type)
                REQ_LOAD: begin
                    o_store_wr.en = 1'b1;
                end
                REQ_START: begin
                    if (r_phase != PH_IDLE
                        || (i_item.tx_count == 8'd0 && i_item.rx_size == 9'd0)) begin
                        o_result.rejected = 1'b1;
                    end else begin
                        n_addr  = i_item.slave_address;
                        n_txc   = i_item.tx_count;
                        n_rxs   = i_item.rx_size;
                        n_wmode = i_item.tx_count != 8'd0;
                        n_err   = 1'b0;
                        n_await = 1'b0;
                        n_pos   = 9'd0;
                        n_limit = 9'd0;
                        n_sum   = 8'd0;
                        n_phase = PH_ADDR;
                        o_result.bus_command = CMD_START;
                    end
                end
                REQ_EVENT: begin
                    case (r_phase)
                        PH_ADDR: begin
                            if (i_item.arbitration_lost) begin
                                o_result.bus_command = CMD_START;
                            end else begin
                                o_result.bus_command = CMD_SEND;
                                o_result.send_byte   = addr_byte;
                                n_pos   = 9'd0;
                                n_sum   = addr_byte;
                                n_phase = r_wmode ? PH_SLEN : PH_RSTART;
                            end
                        end
                        PH_SLEN, PH_SDATA, PH_SCHK, PH_SFIN: begin
                            if (i_item.arbitration_lost) begin
                                o_result.bus_command = CMD_START;
                                n_phase = PH_ADDR;
                            end else if (i_item.slave_acked && r_phase != PH_SFIN) begin
                                o_result.bus_command = CMD_SEND;
                                if (r_phase == PH_SLEN) begin
                                    n_sum = r_sum + r_txc;
                                    o_result.send_byte = r_txc;
                                    n_phase = (r_txc != 8'd0) ? PH_SDATA : PH_SCHK;
                                end else if (r_phase == PH_SDATA) begin
                                    n_pos = pos_inc;
                                    n_sum = r_sum + i_rd_data;
                                    o_result.send_byte = i_rd_data;
                                    if (pos_inc == {1'b0, r_txc}) begin
                                        n_phase = PH_SCHK;
                                    end
                                end else begin
                                    o_result.send_byte = r_sum;
                                    n_phase = PH_SFIN;
                                end
                            end else if (r_rxs != 9'd0) begin
                                o_result.bus_command = CMD_RSTART;
                                n_wmode = 1'b0;
                                n_phase = PH_ADDR;
                            end else begin
                                o_result.bus_command = CMD_STOP;
                                n_phase = PH_WSTOP;
                            end
                        end
                        PH_RSTART: begin
                            if (i_item.slave_acked) begin
                                o_result.bus_command = CMD_CLOCK;
                                n_phase = PH_RLEN;
                            end else begin
                                o_result.bus_command = CMD_STOP;
                                n_phase = PH_WSTOP;
                            end
                        end
                        PH_RLEN: begin
                            n_limit = rlen_min;
                            n_sum   = r_sum + i_item.received_byte;
                            n_await = 1'b1;
                            n_phase = (rlen_min != 9'd0) ? PH_RDATA : PH_RCHK;
                            o_result.bus_command = CMD_ACK;
                        end
                        PH_RDATA: begin
                            if (r_await) begin
                                o_result.bus_command = CMD_CLOCK;
                                n_await = 1'b0;
                            end else begin
                                o_result.rx_valid    = 1'b1;
                                o_result.rx_index    = r_pos[7:0];
                                o_result.rx_data     = i_item.received_byte;
                                o_result.bus_command = CMD_ACK;
                                n_pos   = pos_inc;
                                n_sum   = r_sum + i_item.received_byte;
                                n_await = 1'b1;
                                if (pos_inc == r_limit) begin
                                    n_phase = PH_RCHK;
                                end
                            end
                        end
                        PH_RCHK: begin
                            if (r_await) begin
                                o_result.bus_command = CMD_CLOCK;
                                n_await = 1'b0;
                            end else begin
                                if (i_item.received_byte != r_sum) begin
                                    n_err = 1'b1;
                                end
                                o_result.bus_command = CMD_STOP;
                                n_phase = PH_WSTOP;
                            end
                        end
                        PH_WSTOP: begin
                            o_result.done_res = 1'b1;
                            o_result.rx_count = r_wmode ? 9'd0 : r_pos;
                            n_phase = PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        o_result.checksum_error = n_err;
        o_result.busy_res       = n_phase != PH_IDLE;
    end

    assign o_rd_pos = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wmode <= 1'b0;
            r_pos   <= 9'd0;
            r_limit <= 9'd0;
            r_sum   <= 8'd0;
            r_await <= 1'b0;
            r_addr  <= 7'd0;
            r_txc   <= 8'd0;
            r_rxs   <= 9'd0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_wmode <= n_wmode;
            r_pos   <= n_pos;
            r_limit <= n_limit;
            r_sum   <= n_sum;
            r_await <= n_await;
            r_addr  <= n_addr;
            r_txc   <= n_txc;
            r_rxs   <= n_rxs;
            r_err   <= n_err;
        end
    end

endmodule

// ===== rtl/i2c_framed_master_transaction_core.sv =====
`timescale 1ns / 1ps
// Top level of the framed I2C master transaction core: input and result registers.
// Depends on i2cfm_pkg, i2cfm_seq and i2cfm_tx_store.
//
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_item (t_in_item)
// result    out        o_valid / i_stall   o_item (t_out_item)
//
// One transaction is accepted per cycle unless stalled; its result is registered.
// The transmit store's registered port is read ahead at the next byte position.
// Reset is synchronous and active low; the store itself is not cleared.
// A stalled result holds the input register, which then stalls the input side.
module i2c_framed_master_transaction_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  i2cfm_pkg::t_in_item   i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output i2cfm_pkg::t_out_item  o_item
);
    import i2cfm_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       fire;
    logic       in_accept;
    t_out_item  result;
    t_store_wr  store_wr;
    logic [8:0] rd_pos;
    logic [7:0] rd_data;

    assign fire      = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !fire;
    assign in_accept = i_valid && !o_stall;

    i2cfm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (r_in),
        .i_rd_data  (rd_data),
        .o_store_wr (store_wr),
        .o_rd_pos   (rd_pos),
        .o_result   (result)
    );

    i2cfm_tx_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_pos  (rd_pos),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_item;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== rtl/i2cfm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the framed I2C master transaction core, bound to the top level.
// Depends on i2cfm_pkg for the result struct and command codes.
module i2cfm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input i2cfm_pkg::t_out_item  o_item
);
    import i2cfm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("Stalled result changed.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.done_res |-> !o_item.busy_res && o_item.bus_command == CMD_NONE)
        else $error("Finished transaction still busy or issuing a command.");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.rejected |-> o_item.bus_command == CMD_NONE && !o_item.rx_valid)
        else $error("Refused start produced bus activity.");

    a_rx_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.rx_valid |-> o_item.bus_command == CMD_ACK && o_item.busy_res)
        else $error("Received byte delivered without an acknowledge.");

    a_send_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.bus_command != CMD_SEND |-> o_item.send_byte == 8'd0)
        else $error("Send byte driven without a send command.");

endmodule

bind i2c_framed_master_transaction_core i2cfm_checker u_i2cfm_checker (.*);

// ===== bench/tb_i2c_framed_master_transaction_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for i2c_framed_master_transaction_core: a directed table, then random
// framed transactions checked against a predictor of the sequencer.
// Depends on i2cfm_pkg and the core RTL.
module tb_i2c_framed_master_transaction_core;
    import i2cfm_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1750;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_ADDR, SQ_SLEN, SQ_SDATA, SQ_SCHK, SQ_SFIN,
        SQ_RSTART, SQ_RLEN, SQ_RDATA, SQ_RCHK, SQ_WSTOP
    } seq_state_t;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } dir_row_t;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    i2c_framed_master_transaction_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    seq_state_t ph;
    logic       wr_mode;
    logic [8:0] pos;
    logic [8:0] rd_limit;
    logic [7:0] csum;
    logic       wait_clk;
    logic [6:0] addr_hold;
    logic [7:0] txc_hold;
    logic [8:0] rxs_hold;
    logic       chk_err;
    logic [7:0] tx_mem [256];

    t_out_item exp_q [$];
    dir_row_t  dir_rows [$];
    int send_idle_pct = 33;
    int recv_idle_pct = 47;
    bit hold_req = 0;
    int n_items = 0;
    int n_err = 0;
    int n_frames = 0;
    int n_rx_bytes = 0;
    int n_rejects = 0;
    int arb_left = 0;

    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item  r;
        logic [7:0] d;
        logic [7:0] ab;
        logic [8:0] rb9;
        r = '0;
        rb9 = {1'b0, it.received_byte};
        case (it.req_type)
            REQ_LOAD: begin
                tx_mem[it.load_index] = it.load_byte;
            end
            REQ_START: begin
                if (ph != SQ_IDLE || (it.tx_count == 8'd0 && it.rx_size == 9'd0)) begin
                    r.rejected = 1'b1;
                end else begin
                    addr_hold = it.slave_address;
                    txc_hold = it.tx_count;
                    rxs_hold = it.rx_size;
                    wr_mode = (it.tx_count != 8'd0);
                    chk_err = 1'b0;
                    wait_clk = 1'b0;
                    pos = '0;
                    rd_limit = '0;
                    csum = '0;
                    ph = SQ_ADDR;
                    r.bus_command = CMD_START;
                end
            end
            REQ_EVENT: begin
                case (ph)
                    SQ_ADDR: begin
                        if (it.arbitration_lost) begin
                            r.bus_command = CMD_START;
                        end else begin
                            ab = {addr_hold, ~wr_mode};
                            r.bus_command = CMD_SEND;
                            r.send_byte = ab;
                            pos = '0;
                            csum = ab;
                            ph = wr_mode ? SQ_SLEN : SQ_RSTART;
                        end
                    end
                    SQ_SLEN, SQ_SDATA, SQ_SCHK, SQ_SFIN: begin
                        if (it.arbitration_lost) begin
                            r.bus_command = CMD_START;
                            ph = SQ_ADDR;
                        end else if (it.slave_acked && ph != SQ_SFIN) begin
                            r.bus_command = CMD_SEND;
                            if (ph == SQ_SLEN) begin
                                csum = csum + txc_hold;
                                r.send_byte = txc_hold;
                                ph = (txc_hold != 8'd0) ? SQ_SDATA : SQ_SCHK;
                            end else if (ph == SQ_SDATA) begin
                                d = (pos < 9'd256) ? tx_mem[pos[7:0]] : 8'h00;
                                pos = pos + 9'd1;
                                csum = csum + d;
                                r.send_byte = d;
                                if (pos == {1'b0, txc_hold}) ph = SQ_SCHK;
                            end else begin
                                r.send_byte = csum;
                                ph = SQ_SFIN;
                            end
                        end else if (rxs_hold != 9'd0) begin
                            r.bus_command = CMD_RSTART;
                            wr_mode = 1'b0;
                            ph = SQ_ADDR;
                        end else begin
                            r.bus_command = CMD_STOP;
                            ph = SQ_WSTOP;
                        end
                    end
                    SQ_RSTART: begin
                        if (it.slave_acked) begin
                            r.bus_command = CMD_CLOCK;
                            ph = SQ_RLEN;
                        end else begin
                            r.bus_command = CMD_STOP;
                            ph = SQ_WSTOP;
                        end
                    end
                    SQ_RLEN: begin
                        rd_limit = (rxs_hold < rb9) ? rxs_hold : rb9;
                        csum = csum + it.received_byte;
                        r.bus_command = CMD_ACK;
                        wait_clk = 1'b1;
                        ph = (rd_limit != 9'd0) ? SQ_RDATA : SQ_RCHK;
                    end
                    SQ_RDATA: begin
                        if (wait_clk) begin
                            r.bus_command = CMD_CLOCK;
                            wait_clk = 1'b0;
                        end else begin
                            r.rx_valid = 1'b1;
                            r.rx_index = pos[7:0];
                            r.rx_data = it.received_byte;
                            pos = pos + 9'd1;
                            csum = csum + it.received_byte;
                            r.bus_command = CMD_ACK;
                            wait_clk = 1'b1;
                            if (pos == rd_limit) ph = SQ_RCHK;
                        end
                    end
                    SQ_RCHK: begin
                        if (wait_clk) begin
                            r.bus_command = CMD_CLOCK;
                            wait_clk = 1'b0;
                        end else begin
                            if (it.received_byte != csum) chk_err = 1'b1;
                            r.bus_command = CMD_STOP;
                            ph = SQ_WSTOP;
                        end
                    end
                    SQ_WSTOP: begin
                        r.done_res = 1'b1;
                        r.rx_count = wr_mode ? 9'd0 : pos;
                        ph = SQ_IDLE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.checksum_error = chk_err;
        r.busy_res = (ph != SQ_IDLE);
        return r;
    endfunction

    function automatic t_in_item in_item(logic [1:0] req, logic [6:0] addr, logic [7:0] txc,
                                         logic [8:0] rxs, logic [7:0] idx, logic [7:0] dat,
                                         logic arb, logic ack, logic [7:0] rb);
        t_in_item it;
        it.req_type = req;
        it.slave_address = addr;
        it.tx_count = txc;
        it.rx_size = rxs;
        it.load_index = idx;
        it.load_byte = dat;
        it.arbitration_lost = arb;
        it.slave_acked = ack;
        it.received_byte = rb;
        return it;
    endfunction

    function automatic t_out_item out_item(logic [2:0] cmd, logic [7:0] sb, logic rxv,
                                           logic [7:0] rxi, logic [7:0] rxd, logic done,
                                           logic err, logic [8:0] cnt, logic rej, logic busy);
        t_out_item r;
        r.bus_command = cmd;
        r.send_byte = sb;
        r.rx_valid = rxv;
        r.rx_index = rxi;
        r.rx_data = rxd;
        r.done_res = done;
        r.checksum_error = err;
        r.rx_count = cnt;
        r.rejected = rej;
        r.busy_res = busy;
        return r;
    endfunction

    function automatic dir_row_t row(t_in_item it, bit typed, t_out_item res);
        dir_row_t d;
        d.it = it;
        d.typed = typed;
        d.res = res;
        return d;
    endfunction

    function automatic t_in_item noise_item(logic [1:0] req);
        return in_item(req, 7'($urandom), 8'($urandom), 9'($urandom), 8'($urandom),
                       8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
    endfunction

    function automatic t_in_item make_start();
        t_in_item it;
        int sel;
        it = noise_item(REQ_START);
        sel = $urandom_range(99);
        if (sel < 15) it.tx_count = 8'd0;
        else if (sel < 17) it.tx_count = 8'd255;
        else if (sel < 20) it.tx_count = 8'($urandom_range(255));
        else it.tx_count = 8'($urandom_range(1, 6));
        sel = $urandom_range(99);
        if (sel < 35) it.rx_size = 9'd0;
        else if (sel < 45) it.rx_size = 9'($urandom_range(256, 511));
        else if (sel < 90) it.rx_size = 9'($urandom_range(1, 8));
        else it.rx_size = 9'($urandom_range(511));
        if (it.tx_count == 8'd0 && it.rx_size == 9'd0 && $urandom_range(3) != 0)
            it.tx_count = 8'd1;
        return it;
    endfunction

    function automatic t_in_item make_event(bit allow_arb);
        t_in_item it;
        it = noise_item(REQ_EVENT);
        case (ph)
            SQ_ADDR, SQ_SLEN, SQ_SDATA, SQ_SCHK, SQ_SFIN: begin
                it.arbitration_lost = allow_arb && ($urandom_range(99) < 4);
                it.slave_acked = ($urandom_range(99) < 93);
            end
            SQ_RSTART: it.slave_acked = ($urandom_range(99) < 90);
            SQ_RLEN: begin
                if ($urandom_range(99) >= 4) it.received_byte = 8'($urandom_range(6));
            end
            SQ_RCHK: begin
                if (!wait_clk && $urandom_range(99) < 85) it.received_byte = csum;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic check_result(input t_out_item e, input t_out_item a);
        if (a.bus_command !== e.bus_command) begin
            $error("bus_command: expected %0d, actual %0d", e.bus_command, a.bus_command);
            n_err++;
        end
        if (a.send_byte !== e.send_byte) begin
            $error("send_byte: expected %0h, actual %0h", e.send_byte, a.send_byte);
            n_err++;
        end
        if (a.rx_valid !== e.rx_valid) begin
            $error("rx_valid: expected %0d, actual %0d", e.rx_valid, a.rx_valid);
            n_err++;
        end
        if (a.rx_index !== e.rx_index) begin
            $error("rx_index: expected %0d, actual %0d", e.rx_index, a.rx_index);
            n_err++;
        end
        if (a.rx_data !== e.rx_data) begin
            $error("rx_data: expected %0h, actual %0h", e.rx_data, a.rx_data);
            n_err++;
        end
        if (a.done_res !== e.done_res) begin
            $error("done_res: expected %0d, actual %0d", e.done_res, a.done_res);
            n_err++;
        end
        if (a.checksum_error !== e.checksum_error) begin
            $error("checksum_error: expected %0d, actual %0d", e.checksum_error,
                   a.checksum_error);
            n_err++;
        end
        if (a.rx_count !== e.rx_count) begin
            $error("rx_count: expected %0d, actual %0d", e.rx_count, a.rx_count);
            n_err++;
        end
        if (a.rejected !== e.rejected) begin
            $error("rejected: expected %0d, actual %0d", e.rejected, a.rejected);
            n_err++;
        end
        if (a.busy_res !== e.busy_res) begin
            $error("busy_res: expected %0d, actual %0d", e.busy_res, a.busy_res);
            n_err++;
        end
    endtask

    task automatic push_txn(input t_in_item it, input bit typed, input t_out_item res);
        t_out_item r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall);
        r = predict_result(it);
        n_items++;
        if (r.done_res) n_frames++;
        if (r.rx_valid) n_rx_bytes++;
        if (r.rejected) n_rejects++;
        exp_q.push_back(typed ? res : r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (exp_q.size() == 0);
    endtask

    task automatic run_transaction();
        t_in_item ev;
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) push_txn(noise_item(REQ_EVENT), 1'b0, '0);
        else if (sel < 5) push_txn(noise_item(REQ_UNUSED), 1'b0, '0);
        else if (sel < 8) push_txn(noise_item(REQ_LOAD), 1'b0, '0);
        arb_left = 2;
        push_txn(make_start(), 1'b0, '0);
        while (ph != SQ_IDLE) begin
            sel = $urandom_range(99);
            if (sel < 4) begin
                push_txn(noise_item(REQ_LOAD), 1'b0, '0);
            end else if (sel < 6) begin
                push_txn(make_start(), 1'b0, '0);
            end else if (sel < 7) begin
                push_txn(noise_item(REQ_UNUSED), 1'b0, '0);
            end else begin
                ev = make_event(arb_left > 0);
                if (ev.arbitration_lost && ph inside {SQ_ADDR, SQ_SLEN, SQ_SDATA, SQ_SCHK, SQ_SFIN})
                    arb_left--;
                push_txn(ev, 1'b0, '0);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (exp_q.size() == 0) begin
                    $error("unexpected result transaction");
                    n_err++;
                end else begin
                    check_result(exp_q.pop_front(), o_item);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int bound;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item = '0;
        ph = SQ_IDLE;
        wr_mode = 1'b0;
        pos = '0;
        rd_limit = '0;
        csum = '0;
        wait_clk = 1'b0;
        addr_hold = '0;
        txc_hold = '0;
        rxs_hold = '0;
        chk_err = 1'b0;
        foreach (tx_mem[a]) tx_mem[a] = '0;

        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 1, 0), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(in_item(REQ_UNUSED, 7'h7f, 8'hff, 9'h1ff, 8'hff, 8'hff, 1, 1,
                                       8'hff), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(in_item(REQ_START, 7'h55, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 1, 0)));
        dir_rows.push_back(row(in_item(REQ_LOAD, 0, 0, 0, 8'd0, 8'hff, 0, 0, 0), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(in_item(REQ_LOAD, 0, 0, 0, 8'd255, 8'h00, 0, 0, 0), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(in_item(REQ_LOAD, 0, 0, 0, 8'd1, 8'ha5, 0, 0, 0), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(in_item(REQ_START, 7'h7f, 8'd2, 9'd256, 0, 0, 0, 0, 0), 1'b1,
                               out_item(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(row(in_item(REQ_START, 7'h00, 8'd255, 9'd511, 0, 0, 0, 0, 0), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 1, 1)));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 1, 0, 0), 1'b1,
                               out_item(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 1, 1, 0), 1'b0, '0));
        for (int k = 0; k < 6; k++)
            dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 0, 8'd1), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 0, 8'h00), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 0, 8'h5a), 1'b1,
                               out_item(CMD_STOP, 0, 0, 0, 0, 0, 1, 0, 0, 1)));
        dir_rows.push_back(row(in_item(REQ_EVENT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               out_item(CMD_NONE, 0, 0, 0, 0, 1, 1, 9'd1, 0, 0)));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) push_txn(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);
        drain();

        // Every store entry is written before any random transaction can send it.
        for (int a = 0; a < 256; a++) begin
            push_txn(in_item(REQ_LOAD, 7'($urandom), 8'($urandom), 9'($urandom), 8'(a),
                             8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom)),
                     1'b0, '0);
        end

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 33 : (p == 1) ? 47 : 0;
            recv_idle_pct = (p == 0) ? 47 : (p == 1) ? 33 : 0;
            if (p == 2) hold_req = 1;
            bound = n_items + (ITEM_TARGET - n_items) / (3 - p);
            while (n_items < bound) run_transaction();
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("Ran %0d transactions: %0d framed transfers finished, %0d bytes read back,",
                 n_items, n_frames, n_rx_bytes);
        $display("%0d starts refused, under three idling profiles and a long result hold.",
                 n_rejects);
        if (n_err == 0 && exp_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== i2c_framed_master_transaction_core.f =====
rtl/i2cfm_pkg.sv
rtl/i2cfm_tx_store.sv
rtl/i2cfm_seq.sv
rtl/i2c_framed_master_transaction_core.sv
rtl/i2cfm_checker.sv
bench/tb_i2c_framed_master_transaction_core.sv
